/* hdl/tbi_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tbi_pkg
// Types, constants and codes shared by the table bracket interpolator.
// ----------------------------------------------------------------------------
package tbi_pkg;

   localparam int DEF_ROWS        = 128;
   localparam int DEF_COLUMNS     = 6;
   localparam int DEF_VALUE_BITS  = 48;

   localparam int FRAC_BITS       = 24;
   localparam int FIELD_BITS      = 48;
   localparam int OUT_COLS        = 6;
   localparam int ITEM_VALUE_BITS = 64;
   localparam int MUL_BITS        = 32;
   localparam int QDEPTH          = 2;

   localparam logic [7:0] RESET_ROWS_IN_USE = 8'd121;
   localparam logic [2:0] RESET_DESC_COLUMN = 3'd4;

   localparam logic REG_ROWS_IN_USE = 1'b0;
   localparam logic REG_DESC_COLUMN = 1'b1;

   localparam logic REQ_LOAD   = 1'b0;
   localparam logic REQ_LOOKUP = 1'b1;

   typedef enum logic [1:0] {
      KIND_LOAD,
      KIND_LOOKUP,
      KIND_MISS
   } kind_type;

   typedef struct packed {
      kind_type                   kind;
      logic [2:0]                 column;
      logic [6:0]                 row;
      logic [ITEM_VALUE_BITS-1:0] value;
   } item_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DIV,
      ST_RD_A,
      ST_RD_B,
      ST_DIFF,
      ST_MUL_LO,
      ST_MUL_HI
   } state_type;

endpackage

`default_nettype wire

/* hdl/tbi_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tbi_front
// Accepts, classifies and queues words for the back end; drops off-table loads.
// ----------------------------------------------------------------------------
module tbi_front import tbi_pkg::*; #(
   parameter int ROWS       = DEF_ROWS,
   parameter int COLUMNS    = DEF_COLUMNS,
   parameter int VALUE_BITS = DEF_VALUE_BITS
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   start,
   output logic                  busy,
   input  wire                   req_type,
   input  wire [2:0]             req_column,
   input  wire [6:0]             req_row,
   input  wire [VALUE_BITS-1:0]  req_load_value,
   input  wire [VALUE_BITS-1:0]  req_query_value,
   output logic                  q_valid,
   output item_type              q_item,
   input  wire                   q_pop
);

   localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int CW = $clog2(QDEPTH + 1);

   item_type        qmem_ff [QDEPTH];
   logic [PW-1:0]   wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [CW-1:0]   count_ff, count_in;
   item_type        item;
   logic            keep, push;

   always_comb begin
      item.column = req_column;
      item.row    = req_row;
      keep        = 1'b1;
      if (req_type == REQ_LOAD) begin
         item.kind  = KIND_LOAD;
         item.value = ITEM_VALUE_BITS'(req_load_value);
         keep = (32'(req_column) < COLUMNS) && (32'(req_row) < ROWS);
      end else begin
         item.kind  = (32'(req_column) < COLUMNS) ? KIND_LOOKUP : KIND_MISS;
         item.value = ITEM_VALUE_BITS'(req_query_value);
      end
   end

   assign busy    = (count_ff == CW'(QDEPTH));
   assign push    = start && !busy && keep;
   assign q_valid = (count_ff != '0);
   assign q_item  = qmem_ff[rptr_ff];

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (push) begin
         wptr_in = (wptr_ff == PW'(QDEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (q_pop && q_valid) begin
         rptr_in = (rptr_ff == PW'(QDEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      case ({push, q_pop && q_valid})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         qmem_ff[wptr_ff] <= item;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(QDEPTH)) else $error("queue count overflow");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> !q_valid) else $error("pop from empty queue");
   a_full_busy: assert property (@(posedge clock) disable iff (reset)
      busy |=> (count_ff != '0)) else $error("full queue emptied at once");

endmodule

`default_nettype wire

/* hdl/tbi_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tbi_back
// Holds the table; runs the bracket scan, fraction divide and interpolation.
// ----------------------------------------------------------------------------
module tbi_back import tbi_pkg::*; #(
   parameter int ROWS       = DEF_ROWS,
   parameter int COLUMNS    = DEF_COLUMNS,
   parameter int VALUE_BITS = DEF_VALUE_BITS
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  q_valid,
   input  item_type                             q_item,
   output logic                                 q_pop,
   input  wire [7:0]                            rows_in_use,
   input  wire [2:0]                            desc_column,
   output logic                                 rsp_valid,
   output logic                                 rsp_status,
   output logic [OUT_COLS-1:0][FIELD_BITS-1:0]  rsp_value
);

   localparam int DEPTH     = ROWS * COLUMNS;
   localparam int AW        = $clog2(DEPTH);
   localparam int IW        = $clog2(ROWS + 1);
   localparam int OUT_N     = (COLUMNS < OUT_COLS) ? COLUMNS : OUT_COLS;
   localparam int JW        = $clog2(OUT_COLS);
   localparam int PROD_BITS = FRAC_BITS + MUL_BITS;
   localparam int HI_SHIFT  = MUL_BITS - FRAC_BITS;

   logic [VALUE_BITS-1:0] table_mem [DEPTH];
   logic [VALUE_BITS-1:0] rdata_ff;
   logic                  we;
   logic [AW-1:0]         waddr, raddr;

   state_type             state_ff, state_in;
   logic [2:0]            col_ff, col_in;
   logic                  desc_ff, desc_in;
   logic [VALUE_BITS-1:0] q_ff, q_in, prev_ff, prev_in;
   logic [IW-1:0]         n_ff, n_in, idx_ff, idx_in, chk_ff, chk_in, row_ff, row_in;
   logic                  chk_valid_ff, chk_valid_in;
   logic [VALUE_BITS-1:0] rem_ff, rem_in, den_ff, den_in;
   logic [FRAC_BITS-1:0]  frac_ff, frac_in;
   logic [4:0]            cnt_ff, cnt_in;
   logic [JW-1:0]         j_ff, j_in;
   logic [VALUE_BITS-1:0] a_ff, a_in, d_ff, d_in;
   logic                  neg_ff, neg_in;
   logic [PROD_BITS-1:0]  mult_ff, mult_in, mlo_ff, mlo_in;
   logic [OUT_COLS-1:0][FIELD_BITS-1:0] out_ff, out_in;
   logic                  status_ff, status_in, valid_ff, valid_in;

   logic [VALUE_BITS:0]   two;
   logic [63:0]           d64, scaled, res;
   logic                  hit;
   logic [IW-1:0]         nsat;

   always_comb begin
      state_in     = state_ff;
      col_in       = col_ff;
      desc_in      = desc_ff;
      q_in         = q_ff;
      prev_in      = prev_ff;
      n_in         = n_ff;
      idx_in       = idx_ff;
      chk_in       = chk_ff;
      chk_valid_in = chk_valid_ff;
      row_in       = row_ff;
      rem_in       = rem_ff;
      den_in       = den_ff;
      frac_in      = frac_ff;
      cnt_in       = cnt_ff;
      j_in         = j_ff;
      a_in         = a_ff;
      d_in         = d_ff;
      neg_in       = neg_ff;
      mult_in      = mult_ff;
      mlo_in       = mlo_ff;
      out_in       = out_ff;
      status_in    = status_ff;
      valid_in     = 1'b0;
      q_pop        = 1'b0;
      we           = 1'b0;
      waddr        = AW'(32'(q_item.column) * ROWS + 32'(q_item.row));
      raddr        = AW'(32'(col_ff) * ROWS + 32'(idx_ff));
      two          = {rem_ff, 1'b0};
      d64          = 64'(d_ff);
      hit          = 1'b0;
      scaled       = (64'(mult_ff) << HI_SHIFT) + 64'(mlo_ff >> FRAC_BITS);
      res          = neg_ff ? (64'(a_ff) - scaled) : (64'(a_ff) + scaled);
      nsat         = (32'(rows_in_use) > ROWS) ? IW'(ROWS) : IW'(rows_in_use);
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               case (q_item.kind)
                  KIND_LOAD: begin
                     we = 1'b1;
                  end
                  KIND_LOOKUP: begin
                     col_in       = q_item.column;
                     desc_in      = (q_item.column == desc_column);
                     q_in         = q_item.value[VALUE_BITS-1:0];
                     n_in         = nsat;
                     idx_in       = '0;
                     chk_valid_in = 1'b0;
                     out_in       = '0;
                     if (nsat < IW'(2)) begin
                        status_in = 1'b1;
                        valid_in  = 1'b1;
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
                  default: begin
                     out_in    = '0;
                     status_in = 1'b1;
                     valid_in  = 1'b1;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (idx_ff < n_ff) begin
               idx_in       = idx_ff + 1'b1;
               chk_in       = idx_ff;
               chk_valid_in = 1'b1;
            end else begin
               chk_valid_in = 1'b0;
            end
            if (chk_valid_ff) begin
               prev_in = rdata_ff;
               hit = desc_ff ? (rdata_ff < q_ff) : (rdata_ff > q_ff);
               if (hit && (chk_ff == '0)) begin
                  status_in = 1'b1;
                  valid_in  = 1'b1;
                  state_in  = ST_IDLE;
               end else if (hit) begin
                  rem_in   = desc_ff ? (prev_ff - q_ff) : (q_ff - prev_ff);
                  den_in   = desc_ff ? (prev_ff - rdata_ff) : (rdata_ff - prev_ff);
                  row_in   = chk_ff;
                  cnt_in   = '0;
                  frac_in  = '0;
                  state_in = ST_DIV;
               end else if (chk_ff == n_ff - 1'b1) begin
                  status_in = 1'b1;
                  valid_in  = 1'b1;
                  state_in  = ST_IDLE;
               end
            end
         end
         ST_DIV: begin
            if (two >= {1'b0, den_ff}) begin
               rem_in  = VALUE_BITS'(two - {1'b0, den_ff});
               frac_in = {frac_ff[FRAC_BITS-2:0], 1'b1};
            end else begin
               rem_in  = VALUE_BITS'(two);
               frac_in = {frac_ff[FRAC_BITS-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 5'(FRAC_BITS - 1)) begin
               j_in     = '0;
               state_in = ST_RD_A;
            end
         end
         ST_RD_A: begin
            raddr    = AW'(32'(j_ff) * ROWS + 32'(row_ff) - 1);
            state_in = ST_RD_B;
         end
         ST_RD_B: begin
            raddr    = AW'(32'(j_ff) * ROWS + 32'(row_ff));
            a_in     = rdata_ff;
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            if (rdata_ff >= a_ff) begin
               d_in   = rdata_ff - a_ff;
               neg_in = 1'b0;
            end else begin
               d_in   = a_ff - rdata_ff;
               neg_in = 1'b1;
            end
            state_in = ST_MUL_LO;
         end
         ST_MUL_LO: begin
            mult_in  = PROD_BITS'(frac_ff) * PROD_BITS'(d64[31:0]);
            state_in = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            mlo_in   = mult_ff;
            mult_in  = PROD_BITS'(frac_ff) * PROD_BITS'(d64[63:32]);
            state_in = ST_MUL_HI;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // accumulate step follows the high product; tracked by acc_ff
   logic acc_ff, acc_in;

   always_comb begin
      acc_in = (state_ff == ST_MUL_HI) && !acc_ff;
   end

   logic                 fin_valid, fin_next;
   logic [OUT_COLS-1:0][FIELD_BITS-1:0] fin_out;
   state_type            fin_state;

   always_comb begin
      fin_out   = out_in;
      fin_valid = valid_in;
      fin_state = state_in;
      fin_next  = 1'b0;
      if (state_ff == ST_MUL_HI && acc_ff) begin
         fin_out[j_ff] = res[FIELD_BITS-1:0];
         if (j_ff == JW'(OUT_N - 1)) begin
            fin_valid = 1'b1;
            fin_state = ST_IDLE;
         end else begin
            fin_next  = 1'b1;
            fin_state = ST_RD_A;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         chk_valid_ff <= 1'b0;
         valid_ff     <= 1'b0;
         acc_ff       <= 1'b0;
      end else begin
         state_ff     <= fin_state;
         chk_valid_ff <= chk_valid_in;
         valid_ff     <= fin_valid;
         acc_ff       <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      col_ff    <= col_in;
      desc_ff   <= desc_in;
      q_ff      <= q_in;
      prev_ff   <= prev_in;
      n_ff      <= n_in;
      idx_ff    <= idx_in;
      chk_ff    <= chk_in;
      row_ff    <= row_in;
      rem_ff    <= rem_in;
      den_ff    <= den_in;
      frac_ff   <= frac_in;
      cnt_ff    <= cnt_in;
      j_ff      <= fin_next ? j_ff + 1'b1 : j_in;
      a_ff      <= a_in;
      d_ff      <= d_in;
      neg_ff    <= neg_in;
      mult_ff   <= (state_ff == ST_MUL_HI && acc_ff) ? mult_ff : mult_in;
      mlo_ff    <= (state_ff == ST_MUL_HI && acc_ff) ? mlo_ff : mlo_in;
      out_ff    <= fin_out;
      status_ff <= (state_ff == ST_MUL_HI && acc_ff) ? 1'b0 : status_in;
   end

   always_ff @(posedge clock) begin
      if (we) begin
         table_mem[waddr] <= q_item.value[VALUE_BITS-1:0];
      end
      rdata_ff <= table_mem[raddr];
   end

   assign rsp_valid  = valid_ff;
   assign rsp_status = status_ff;
   assign rsp_value  = out_ff;

   a_valid_idle: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (state_ff == ST_IDLE)) else $error("result strobe while working");
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && status_ff) |-> (out_ff == '0)) else $error("miss with data");
   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (cnt_ff < 5'(FRAC_BITS))) else $error("divide overrun");
   a_busy_no_pop: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !q_pop) else $error("pop while working");

endmodule

`default_nettype wire

/* hdl/table_bracket_interpolator.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// table_bracket_interpolator
// Piecewise linear interpolation over a six-column property table.
// ----------------------------------------------------------------------------
// Load word: queued, then written to the table once the idle back end pops it.
// Lookup word: popped, scanned for its bracket on the table read port, divided for the
//   fraction, then per column read twice, differenced, multiplied and accumulated.
// One lookup at a time; a two-word queue takes start while busy is low.
// Reset: rows_in_use 121, descending_column 4, queue empty; table undefined.
module table_bracket_interpolator import tbi_pkg::*; #(
   parameter int ROWS       = DEF_ROWS,
   parameter int COLUMNS    = DEF_COLUMNS,
   parameter int VALUE_BITS = DEF_VALUE_BITS
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   start,
   output logic                  busy,
   input  wire                   req_type,
   input  wire [2:0]             req_column,
   input  wire [6:0]             req_row,
   input  wire [VALUE_BITS-1:0]  req_load_value,
   input  wire [VALUE_BITS-1:0]  req_query_value,
   output logic                  rsp_valid,
   output logic                  rsp_status,
   output logic [FIELD_BITS-1:0] rsp_temperature,
   output logic [FIELD_BITS-1:0] rsp_enthalpy,
   output logic [FIELD_BITS-1:0] rsp_relative_pressure,
   output logic [FIELD_BITS-1:0] rsp_internal_energy,
   output logic [FIELD_BITS-1:0] rsp_relative_volume,
   output logic [FIELD_BITS-1:0] rsp_entropy,
   input  wire                   psel,
   input  wire                   penable,
   input  wire                   pwrite,
   input  wire [2:0]             paddr,
   input  wire [31:0]            pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   logic [7:0] rows_ff, rows_in;
   logic [2:0] desc_ff, desc_in;
   logic       q_valid, q_pop;
   item_type   q_item;
   logic [OUT_COLS-1:0][FIELD_BITS-1:0] value;

   assign pready = 1'b1;

   always_comb begin
      rows_in = rows_ff;
      desc_in = desc_ff;
      if (psel && penable && pwrite) begin
         case (paddr[2])
            REG_ROWS_IN_USE: rows_in = pwdata[7:0];
            REG_DESC_COLUMN: desc_in = pwdata[2:0];
            default:         rows_in = rows_ff;
         endcase
      end
      case (paddr[2])
         REG_ROWS_IN_USE: prdata = {24'd0, rows_ff};
         REG_DESC_COLUMN: prdata = {29'd0, desc_ff};
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= RESET_ROWS_IN_USE;
         desc_ff <= RESET_DESC_COLUMN;
      end else begin
         rows_ff <= rows_in;
         desc_ff <= desc_in;
      end
   end

   tbi_front #(.ROWS(ROWS), .COLUMNS(COLUMNS), .VALUE_BITS(VALUE_BITS)) u_front (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_type        (req_type),
      .req_column      (req_column),
      .req_row         (req_row),
      .req_load_value  (req_load_value),
      .req_query_value (req_query_value),
      .q_valid         (q_valid),
      .q_item          (q_item),
      .q_pop           (q_pop)
   );

   tbi_back #(.ROWS(ROWS), .COLUMNS(COLUMNS), .VALUE_BITS(VALUE_BITS)) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_item      (q_item),
      .q_pop       (q_pop),
      .rows_in_use (rows_ff),
      .desc_column (desc_ff),
      .rsp_valid   (rsp_valid),
      .rsp_status  (rsp_status),
      .rsp_value   (value)
   );

   assign rsp_temperature       = value[0];
   assign rsp_enthalpy          = value[1];
   assign rsp_relative_pressure = value[2];
   assign rsp_internal_energy   = value[3];
   assign rsp_relative_volume   = value[4];
   assign rsp_entropy           = value[5];

endmodule

`default_nettype wire
